@@ hw/rtl/scsepwm_pkg.sv @@
// ----------------------------------------------------------------------------
// scsepwm_pkg: shared types and constants of the six-channel PWM timer
// Command codes, register map, control bit positions and the result
// word that passes from the timer core to the output stage.
// ----------------------------------------------------------------------------
package scsepwm_pkg;

    // Widths of the stream words.
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 72;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam int PWM_W       = 6;

    // Item kinds carried in tuser.
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // Register map.
    localparam logic [ADDR_W-1:0] ADDR_CTRL   = 4'd0;
    localparam logic [ADDR_W-1:0] ADDR_MCR    = 4'd1;
    localparam logic [ADDR_W-1:0] ADDR_PERIOD = 4'd2;
    localparam logic [ADDR_W-1:0] ADDR_MATCH0 = 4'd3;
    localparam logic [ADDR_W-1:0] ADDR_LATCH  = 4'd9;
    localparam logic [ADDR_W-1:0] ADDR_OUTEN  = 4'd10;

    // Bit positions inside the control registers.
    localparam int CTRL_EN_BIT   = 0;
    localparam int CTRL_PWM_BIT  = 3;
    localparam int MCR_RESET_BIT = 1;

    // One result word.
    typedef struct packed {
        logic [DATA_W-1:0] count;
        logic [PWM_W-1:0]  pwm_out;
        logic [DATA_W-1:0] rdata;
    } t_result;

endpackage

@@ hw/rtl/six_channel_single_edge_pwm.sv @@
// ----------------------------------------------------------------------------
// six_channel_single_edge_pwm: six-channel single-edge PWM timer
// Usage:
//   The slave stream carries one word per tick, register write or register
//   read; tuser holds the kind and tdata the address and the write value.
//   Every accepted word yields exactly one master-side word holding the
//   read data, the gated PWM levels and the counter value after the word.
//   Period and match writes go to shadow registers and reach the active
//   registers at the next period reset when their latch bit is set.
//   The result word appears the cycle after its input word is accepted.
//   Throughput is one word per cycle while the receiver is ready, set by
//   the single pass through the counter compare and register decode.
//   The input is ready whenever the output register is empty or is being
//   taken, so a stalled receiver holds the result and stops the input after
//   one word. Reset clears all timer state, registers and the output valid.
// ----------------------------------------------------------------------------
module six_channel_single_edge_pwm #(
    parameter int CHANNELS    = 6,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // tdata fields from bit 0: reg_addr[3:0], wdata[35:4], zero fill [39:36]
    input  logic [scsepwm_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // tuser fields from bit 0: cmd[1:0]
    input  logic [scsepwm_pkg::IN_TUSER_W-1:0]    i_s_tuser,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // tdata fields from bit 0: rdata[31:0], pwm_out[37:32], count[69:38],
    // zero fill [71:70]
    output logic [scsepwm_pkg::OUT_TDATA_W-1:0]   o_m_tdata
);

    logic                 accept;
    scsepwm_pkg::t_cmd    cmd;
    scsepwm_pkg::t_result result;
    scsepwm_pkg::t_result r_out;
    logic                 r_out_valid;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign cmd        = scsepwm_pkg::t_cmd'(i_s_tuser);

    // Timer core.
    scsepwm_core #(
        .CHANNELS    (CHANNELS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_cmd    (cmd),
        .i_addr   (i_s_tdata[scsepwm_pkg::ADDR_W-1:0]),
        .i_wdata  (i_s_tdata[scsepwm_pkg::ADDR_W +: scsepwm_pkg::DATA_W]),
        .o_result (result)
    );

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_out_valid <= i_s_tvalid;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = scsepwm_pkg::OUT_TDATA_W'(r_out);

endmodule

@@ hw/rtl/scsepwm_core.sv @@
// ----------------------------------------------------------------------------
// scsepwm_core: register file, counter and channel logic of the PWM timer
// Applies one tick, write or read per accepted word and presents the
// result word that follows from it in the same cycle.
// ----------------------------------------------------------------------------
module scsepwm_core #(
    parameter int CHANNELS    = 6,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  scsepwm_pkg::t_cmd                i_cmd,
    input  logic [scsepwm_pkg::ADDR_W-1:0]   i_addr,
    input  logic [scsepwm_pkg::DATA_W-1:0]   i_wdata,
    output scsepwm_pkg::t_result             o_result
);

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Timer state.
    logic [COUNT_WIDTH-1:0] r_count,      n_count;
    logic                   r_cnt_en,     n_cnt_en;
    logic                   r_pwm_mode,   n_pwm_mode;
    logic                   r_ror,        n_ror;
    logic [COUNT_WIDTH-1:0] r_period_sh,  n_period_sh;
    logic [COUNT_WIDTH-1:0] r_period_act, n_period_act;
    logic [COUNT_WIDTH-1:0] r_match_sh  [CHANNELS];
    logic [COUNT_WIDTH-1:0] n_match_sh  [CHANNELS];
    logic [COUNT_WIDTH-1:0] r_match_act [CHANNELS];
    logic [COUNT_WIDTH-1:0] n_match_act [CHANNELS];
    logic [CHANNELS:0]      r_latch,      n_latch;
    logic [CHANNELS-1:0]    r_outen,      n_outen;
    logic [CHANNELS-1:0]    r_level,      n_level;

    logic [COUNT_WIDTH-1:0]         cnt_inc;
    logic                           wrap;
    logic [scsepwm_pkg::ADDR_W-1:0] addr_off;
    logic                           is_match;
    logic [CH_IDX_W-1:0]            ch_idx;
    logic [scsepwm_pkg::DATA_W-1:0] rdata;
    logic [CHANNELS-1:0]            pwm_vis;

    // Match register decode.
    assign addr_off = i_addr - scsepwm_pkg::ADDR_MATCH0;
    assign is_match = (i_addr >= scsepwm_pkg::ADDR_MATCH0)
                      && (addr_off < scsepwm_pkg::ADDR_W'(CHANNELS));
    assign ch_idx   = addr_off[CH_IDX_W-1:0];

    // Next state and read data for the word at the input.
    always_comb begin
        n_count      = r_count;
        n_cnt_en     = r_cnt_en;
        n_pwm_mode   = r_pwm_mode;
        n_ror        = r_ror;
        n_period_sh  = r_period_sh;
        n_period_act = r_period_act;
        n_match_sh   = r_match_sh;
        n_match_act  = r_match_act;
        n_latch      = r_latch;
        n_outen      = r_outen;
        n_level      = r_level;
        cnt_inc      = r_count + COUNT_WIDTH'(1);
        wrap         = 1'b0;
        rdata        = '0;
        unique case (i_cmd)
            scsepwm_pkg::CMD_TICK: begin
                if (r_cnt_en) begin
                    wrap    = r_ror && (cnt_inc == r_period_act);
                    n_count = wrap ? '0 : cnt_inc;
                    // Period reset: load pending shadows, then raise enabled channels.
                    if (wrap) begin
                        if (r_latch[0]) begin
                            n_period_act = r_period_sh;
                        end
                        for (int ch = 0; ch < CHANNELS; ch++) begin
                            if (r_latch[ch+1]) begin
                                n_match_act[ch] = r_match_sh[ch];
                            end
                        end
                        n_latch = '0;
                        if (r_pwm_mode) begin
                            for (int ch = 0; ch < CHANNELS; ch++) begin
                                if (r_outen[ch] && (n_match_act[ch] != '0)) begin
                                    n_level[ch] = 1'b1;
                                end
                            end
                        end
                    end
                    // A match drops its channel.
                    if (r_pwm_mode) begin
                        for (int ch = 0; ch < CHANNELS; ch++) begin
                            if (n_count == n_match_act[ch]) begin
                                n_level[ch] = 1'b0;
                            end
                        end
                    end
                end
            end
            scsepwm_pkg::CMD_WRITE: begin
                priority if (i_addr == scsepwm_pkg::ADDR_CTRL) begin
                    n_cnt_en   = i_wdata[scsepwm_pkg::CTRL_EN_BIT];
                    n_pwm_mode = i_wdata[scsepwm_pkg::CTRL_PWM_BIT];
                end else if (i_addr == scsepwm_pkg::ADDR_MCR) begin
                    n_ror = i_wdata[scsepwm_pkg::MCR_RESET_BIT];
                end else if (i_addr == scsepwm_pkg::ADDR_PERIOD) begin
                    n_period_sh = i_wdata[COUNT_WIDTH-1:0];
                end else if (is_match) begin
                    n_match_sh[ch_idx] = i_wdata[COUNT_WIDTH-1:0];
                end else if (i_addr == scsepwm_pkg::ADDR_LATCH) begin
                    n_latch = i_wdata[CHANNELS:0];
                end else if (i_addr == scsepwm_pkg::ADDR_OUTEN) begin
                    n_outen = i_wdata[CHANNELS-1:0];
                end else begin
                end
            end
            scsepwm_pkg::CMD_READ: begin
                priority if (i_addr == scsepwm_pkg::ADDR_CTRL) begin
                    rdata[scsepwm_pkg::CTRL_EN_BIT]  = r_cnt_en;
                    rdata[scsepwm_pkg::CTRL_PWM_BIT] = r_pwm_mode;
                end else if (i_addr == scsepwm_pkg::ADDR_MCR) begin
                    rdata[scsepwm_pkg::MCR_RESET_BIT] = r_ror;
                end else if (i_addr == scsepwm_pkg::ADDR_PERIOD) begin
                    rdata = scsepwm_pkg::DATA_W'(r_period_sh);
                end else if (is_match) begin
                    rdata = scsepwm_pkg::DATA_W'(r_match_sh[ch_idx]);
                end else if (i_addr == scsepwm_pkg::ADDR_LATCH) begin
                    rdata = scsepwm_pkg::DATA_W'(r_latch);
                end else if (i_addr == scsepwm_pkg::ADDR_OUTEN) begin
                    rdata = scsepwm_pkg::DATA_W'(r_outen);
                end else begin
                end
            end
            default: begin
            end
        endcase
    end

    // Visible outputs follow the state after the word.
    assign pwm_vis          = n_pwm_mode ? (n_level & n_outen) : '0;
    assign o_result.rdata   = rdata;
    assign o_result.pwm_out = scsepwm_pkg::PWM_W'(pwm_vis);
    assign o_result.count   = scsepwm_pkg::DATA_W'(n_count);

    // State update on each accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_cnt_en     <= 1'b0;
            r_pwm_mode   <= 1'b0;
            r_ror        <= 1'b0;
            r_period_sh  <= '0;
            r_period_act <= '0;
            for (int ch = 0; ch < CHANNELS; ch++) begin
                r_match_sh[ch]  <= '0;
                r_match_act[ch] <= '0;
            end
            r_latch      <= '0;
            r_outen      <= '0;
            r_level      <= '0;
        end else if (i_accept) begin
            r_count      <= n_count;
            r_cnt_en     <= n_cnt_en;
            r_pwm_mode   <= n_pwm_mode;
            r_ror        <= n_ror;
            r_period_sh  <= n_period_sh;
            r_period_act <= n_period_act;
            r_match_sh   <= n_match_sh;
            r_match_act  <= n_match_act;
            r_latch      <= n_latch;
            r_outen      <= n_outen;
            r_level      <= n_level;
        end
    end

endmodule
